>>> rtl/core/svp_pkg.sv
`timescale 1ns / 1ps
package svp_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned MAX_BYTES = 8;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t             ip;
    word_t             actual;
  } svp_req_t;

  function automatic word_t mask_value(input word_t raw, input logic [SIZE_W-1:0] size);
    word_t m;
    m = '0;
    for (int b = 0; b < MAX_BYTES; b++) begin
      if (b < int'(size)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return raw & m;
  endfunction

endpackage

>>> rtl/core/svp_front.sv
`timescale 1ns / 1ps
// Drops oversized requests, masks the value and pushes into a two-entry queue.
module svp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 in_ip,
  input  logic [63:0]                 in_load_value,
  input  logic [svp_pkg::SIZE_W-1:0]  in_access_size,
  output logic                        q_valid,
  input  logic                        q_ready,
  output svp_pkg::svp_req_t           q_data
);

  svp_pkg::svp_req_t q_mem_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && (in_access_size <= 4'(svp_pkg::MAX_BYTES));
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r].ip     <= in_ip;
      q_mem_r[wp_r].actual <= svp_pkg::mask_value(in_load_value, in_access_size);
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/core/svp_back.sv
`timescale 1ns / 1ps
// Associative lookup, stride update and FIFO replacement; registered result.
// Per request: tag match and value store read, then update.
module svp_back #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        flush,
  input  logic [svp_pkg::CAP_W-1:0]   capacity,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  svp_pkg::svp_req_t           q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_pred_value,
  output logic                        out_hit,
  output logic signed [63:0]          out_new_stride,
  output logic [63:0]                 out_load_count,
  output logic [63:0]                 out_hit_count
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } back_state_t;

  svp_pkg::word_t     tag_r    [ENTRIES];
  svp_pkg::word_t     last_r   [ENTRIES];
  svp_pkg::word_t     stride_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [OCC_W-1:0]   occ_r;
  logic [IDX_W-1:0]   victim_r;
  svp_pkg::word_t     loads_r, hits_r;

  back_state_t        state_r;
  svp_pkg::svp_req_t  req_r;
  logic               found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  svp_pkg::word_t     rd_last_r, rd_stride_r;

  logic               found;
  logic [IDX_W-1:0]   hit_idx, slot;
  logic [OCC_W-1:0]   cap;
  svp_pkg::word_t     pred, stride;
  logic               hit, take, update;

  assign q_ready = (state_r == ST_IDLE) && (!out_valid || out_ready);
  assign take    = q_valid && q_ready;
  assign update  = (state_r == ST_UPDATE);

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && valid_r[i] && tag_r[i] == q_data.ip) begin
        found   = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    if (capacity == '0) begin
      cap = OCC_W'(1);
    end else if (32'(capacity) > ENTRIES) begin
      cap = OCC_W'(ENTRIES);
    end else begin
      cap = OCC_W'(capacity);
    end
    pred   = found_r ? rd_last_r + rd_stride_r : '0;
    stride = found_r ? req_r.actual - rd_last_r : '0;
    hit    = found_r && (pred == req_r.actual);
    if (found_r) begin
      slot = hit_idx_r;
    end else if (occ_r < cap) begin
      slot = occ_r[IDX_W-1:0];
    end else begin
      slot = victim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r       <= q_data;
      found_r     <= found;
      hit_idx_r   <= hit_idx;
      rd_last_r   <= last_r[hit_idx];
      rd_stride_r <= stride_r[hit_idx];
    end
    if (update) begin
      last_r[slot]   <= req_r.actual;
      stride_r[slot] <= stride;
      if (!found_r) tag_r[slot] <= req_r.ip;
      out_pred_value <= pred;
      out_hit        <= hit;
      out_new_stride <= stride;
    end
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      occ_r     <= '0;
      victim_r  <= '0;
      loads_r   <= '0;
      hits_r    <= '0;
      out_valid <= 1'b0;
      out_load_count <= '0;
      out_hit_count  <= '0;
    end else if (flush) begin
      valid_r  <= '0;
      occ_r    <= '0;
      victim_r <= '0;
    end else begin
      out_valid <= update || (out_valid && !out_ready);
      state_r   <= take ? ST_UPDATE : ST_IDLE;
      if (update) begin
        loads_r        <= loads_r + 64'd1;
        hits_r         <= hits_r + 64'(hit);
        out_load_count <= loads_r + 64'd1;
        out_hit_count  <= hits_r + 64'(hit);
        if (!found_r) begin
          valid_r[slot] <= 1'b1;
          if (occ_r < cap) begin
            occ_r <= occ_r + OCC_W'(1);
          end else begin
            victim_r <= (OCC_W'(victim_r) + OCC_W'(1) >= cap) ? '0 : victim_r + IDX_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/stride_value_predictor_top.sv
`timescale 1ns / 1ps
// Stride load-value predictor. Each load request (ip, value, size) yields one result:
// last value plus stride for a matching ip, a hit flag, the updated stride and
// wrapping load and hit counts. Requests with size above 8 are dropped silently.
// A front queue of two entries takes requests. For each request the back end first
// does the fully associative tag match with the value store read, then
// the add, subtract and table update into the result register. The back end
// takes no new request until the last one's update is done, and then only while
// the result register is empty or draining. Writing capacity flushes the table;
// the user must do it only while the block is idle, which the block does not enforce.
module stride_value_predictor_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 in_ip,
  input  logic [63:0]                 in_load_value,
  input  logic [3:0]                  in_access_size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_pred_value,
  output logic                        out_hit,
  output logic signed [63:0]          out_new_stride,
  output logic [63:0]                 out_load_count,
  output logic [63:0]                 out_hit_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [6:0]                  cfg_capacity
);

  logic                       q_valid, q_ready, flush;
  svp_pkg::svp_req_t          q_data;
  logic [svp_pkg::CAP_W-1:0]  cap_r;

  assign cfg_ready = 1'b1;
  assign flush     = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 7'd64;
    end else if (cfg_valid) begin
      cap_r <= cfg_capacity;
    end
  end

  svp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_ip, .in_load_value, .in_access_size,
    .q_valid, .q_ready, .q_data
  );

  svp_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .flush, .capacity(cap_r), .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_pred_value, .out_hit, .out_new_stride,
    .out_load_count, .out_hit_count
  );

endmodule

>>> tb/svp_checker.sv
`timescale 1ns / 1ps
module svp_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [63:0]        in_ip,
  input  logic [63:0]        in_load_value,
  input  logic [3:0]         in_access_size,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [63:0]        out_pred_value,
  input  logic               out_hit,
  input  logic signed [63:0] out_new_stride,
  input  logic [63:0]        out_load_count,
  input  logic [63:0]        out_hit_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [6:0]         cfg_capacity,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct {
    svp_pkg::word_t pred;
    logic           hit;
    svp_pkg::word_t stride;
    svp_pkg::word_t loads;
    svp_pkg::word_t hits;
  } prediction_t;

  prediction_t expected_q[$];
  svp_pkg::word_t tags [ENTRIES];
  svp_pkg::word_t lasts [ENTRIES];
  svp_pkg::word_t strides [ENTRIES];
  bit    valids [ENTRIES];
  int    occupied, victim, cap_reg;
  svp_pkg::word_t loads_total, hits_total;

  function automatic int eff_cap();
    int c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  task automatic flush();
    for (int i = 0; i < ENTRIES; i++) valids[i] = 0;
    occupied = 0;
    victim = 0;
  endtask

  task automatic predict_load(input svp_pkg::word_t ip, input svp_pkg::word_t raw,
                              input logic [3:0] size);
    prediction_t p;
    svp_pkg::word_t actual;
    svp_pkg::word_t msk;
    bit found;
    int slot;
    int c;
    if (size > 8) return;
    msk = (size == 8) ? '1 : ((64'd1 << (8 * size)) - 64'd1);
    actual = raw & msk;
    loads_total++;
    found = 0;
    slot = 0;
    p.pred = '0;
    p.stride = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && valids[i] && tags[i] == ip) begin
        found = 1;
        slot = i;
      end
    end
    if (found) begin
      p.pred = lasts[slot] + strides[slot];
      p.stride = actual - lasts[slot];
    end
    p.hit = found && p.pred == actual;
    if (p.hit) hits_total++;
    if (!found) begin
      c = eff_cap();
      if (occupied < c) begin
        slot = occupied;
        occupied++;
      end else begin
        slot = victim % c;
        victim = (slot + 1) % c;
      end
      tags[slot] = ip;
      valids[slot] = 1;
    end
    lasts[slot] = actual;
    strides[slot] = p.stride;
    p.loads = loads_total;
    p.hits = hits_total;
    expected_q.insert(expected_q.size(), p);
  endtask

  task automatic report(input string what, input svp_pkg::word_t exp_v,
                        input svp_pkg::word_t act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
    cap_reg = 64;
    loads_total = 0;
    hits_total = 0;
    flush();
  end

  always @(posedge clk) begin
    prediction_t e;
    if (!rst_n) begin
      cap_reg = 64;
      loads_total = 0;
      hits_total = 0;
      flush();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          report("unexpected result", '0, out_pred_value);
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (out_pred_value !== e.pred) report("pred_value", e.pred, out_pred_value);
          if (out_hit !== e.hit) report("hit", e.hit, out_hit);
          if (out_new_stride !== e.stride) report("new_stride", e.stride, out_new_stride);
          if (out_load_count !== e.loads) report("load_count", e.loads, out_load_count);
          if (out_hit_count !== e.hits) report("hit_count", e.hits, out_hit_count);
        end
      end
      if (in_valid && in_ready) predict_load(in_ip, in_load_value, in_access_size);
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_capacity;
        flush();
      end
    end
    pending_count = expected_q.size();
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [63:0] in_ip = '0;
  logic [63:0] in_load_value = '0;
  logic [3:0] in_access_size = 4'd1;
  logic out_valid;
  logic out_ready = 0;
  logic [63:0] out_pred_value;
  logic out_hit;
  logic signed [63:0] out_new_stride;
  logic [63:0] out_load_count;
  logic [63:0] out_hit_count;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_capacity = '0;
  int fail_count, pending_count, result_count;
  int cycles = 0;
  int sent = 0;
  bit quiet = 0;
  bit sink_idle = 0;

  always #1 clk = ~clk;

  stride_value_predictor_top DUT (.*);

  svp_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ready <= 1;
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 18);
        out_ready <= 0;
        repeat (n) @(negedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send(input logic [63:0] ip, input logic [63:0] v, input logic [3:0] sz);
    in_valid <= 1;
    in_ip <= ip;
    in_load_value <= v;
    in_access_size <= sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] c);
    drain();
    cfg_valid <= 1;
    cfg_capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic stride_run(input int cap, input int n);
    logic [63:0] ips [8];
    logic [63:0] vals [8];
    logic [63:0] strd [8];
    int k;
    logic [3:0] sz;
    for (int i = 0; i < 8; i++) begin
      ips[i] = {$urandom, $urandom};
      vals[i] = {$urandom, $urandom};
      strd[i] = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(0, 16));
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, (cap < 8 ? cap : 8) - 1);
      if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 7);
      sz = $urandom_range(0, 5) == 0 ? 4'($urandom_range(0, 15)) : 4'd8;
      if ($urandom_range(0, 9) == 0) begin
        send({$urandom, $urandom}, {$urandom, $urandom}, sz);
      end else begin
        send(ips[k], vals[k], sz);
        vals[k] = vals[k] + strd[k];
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, masks, drops, stride
    send('0, '1, 4'd8);
    send('0, '1, 4'd8);
    send('1, 64'h0123456789abcdef, 4'd1);
    send('1, 64'h0123456789abcdef, 4'd0);
    send('1, 64'h0123456789abcdef, 4'd9);
    send('1, 64'h0123456789abcdef, 4'd15);
    send(64'h5555, 64'h10, 4'd8);
    send(64'h5555, 64'h20, 4'd8);
    send(64'h5555, 64'h30, 4'd8);
    send(64'h5555, 64'h28, 4'd8);
    for (int s = 2; s <= 7; s++) send(64'hAAAA, {8{8'h81}}, s[3:0]);
    send(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 4'd8);
    send(64'h8000_0000_0000_0000, 64'h0, 4'd8);
    // idle hold-off until all results are in
    drain();
    write_capacity(7'd0);
    send(64'h1, 64'h1, 4'd8);
    send(64'h2, 64'h2, 4'd8);
    send(64'h1, 64'h1, 4'd8);
    write_capacity(7'd127);
    stride_run(64, 120);
    write_capacity(7'd1);
    stride_run(1, 80);
    write_capacity(7'd3);
    stride_run(3, 150);
    write_capacity(7'd65);
    stride_run(64, 100);
    write_capacity(7'd64);
    stride_run(64, 150);
    write_capacity(7'd5);
    stride_run(5, 100);
    quiet = 1;
    stride_run(5, 100);
    drain();
    $display("ran %0d loads, %0d results, capacities 0,1,3,5,64,65,127", sent, result_count);
    $display("covered masking by size, dropped sizes, stride hits and FIFO eviction");
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
